@@ hdl/tpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// shared widths, register indexes and types of the threshold peak counter
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int CFG_BITS            = 16;
   localparam int CSR_ADDR_BITS       = 1;
   localparam int COUNT_BITS          = 8;
   localparam int GAP_BITS            = 17;
   localparam int SEEN_BITS           = 2;

   // register indexes on the csr channel
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PEAK_THRESHOLD     = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REFRACTORY_SAMPLES = 1'd1;

   // samples held before a center can be tested
   localparam logic [SEEN_BITS-1:0] SEEN_FULL = 2'd2;

   typedef struct packed {
      logic signed [CFG_BITS-1:0] peak_threshold;
      logic        [CFG_BITS-1:0] refractory_samples;
   } cfg_type;

endpackage

@@ hdl/tpc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc channel interfaces
// sample, result and register write channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface tpc_req_if #(
   parameter int SAMPLE_BITS = tpc_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface tpc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             peak_at_middle;
   logic [tpc_pkg::COUNT_BITS-1:0]   peak_count;
   logic                             record_done;

   modport source (output valid, output peak_at_middle, output peak_count,
                   output record_done, input ready);
   modport sink   (input valid, input peak_at_middle, input peak_count,
                   input record_done, output ready);
endinterface

interface tpc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [tpc_pkg::CSR_ADDR_BITS-1:0]  addr;
   logic [tpc_pkg::CFG_BITS-1:0]       data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ hdl/threshold_peak_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_peak_counter
// counts thresholded peaks with a refractory gap in a record of samples
// ----------------------------------------------------------------------------
//  channel | dir | payload                                    | handshake
//  req     | in  | sample, last_sample                        | valid / ready
//  rsp     | out | peak_at_middle, peak_count, record_done    | valid / ready
//  csr     | in  | addr (0 threshold, 1 refractory), data     | valid / ready
//
//  one sample per clock while rsp does not stall; a result shows in the cycle after its transaction
//  the only pipeline register is the result register; req is ready while it
//  is empty or being drained in the same cycle, so stalls on rsp back up req
//  csr writes complete every cycle and must only come while the block is idle
//  reset is synchronous; record state also clears after each last sample
// ----------------------------------------------------------------------------
module threshold_peak_counter
   import tpc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tpc_req_if.sink   req_chan,
   tpc_rsp_if.source rsp_chan,
   tpc_csr_if.sink   csr_chan
);

   cfg_type               cfg;
   logic                  req_take;
   logic                  det_peak;
   logic [COUNT_BITS-1:0] det_count;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_peak_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_done_ff;

   // register writes are never stalled
   assign csr_chan.ready = 1'b1;

   tpc_cfg_regs u_cfg_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_chan.valid),
      .wr_addr (csr_chan.addr),
      .wr_data (csr_chan.data),
      .cfg     (cfg)
   );

   // accept while the result slot is free or emptying this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   tpc_detect #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_detect (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .take        (req_take),
      .sample      (req_chan.sample),
      .last_sample (req_chan.last_sample),
      .peak        (det_peak),
      .count       (det_count)
   );

   // valid follows the transactions in and out
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only loads on a new transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_peak_ff  <= det_peak;
         rsp_count_ff <= det_count;
         rsp_done_ff  <= req_chan.last_sample;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.peak_at_middle = rsp_peak_ff;
   assign rsp_chan.peak_count     = rsp_count_ff;
   assign rsp_chan.record_done    = rsp_done_ff;

endmodule

@@ hdl/tpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_cfg_regs
// threshold and refractory registers written over the csr channel
// ----------------------------------------------------------------------------
module tpc_cfg_regs
   import tpc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [CSR_ADDR_BITS-1:0] wr_addr,
   input  logic [CFG_BITS-1:0]      wr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_addr)
            CSR_PEAK_THRESHOLD:     cfg_in.peak_threshold     = wr_data;
            CSR_REFRACTORY_SAMPLES: cfg_in.refractory_samples = wr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/tpc_detect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_detect
// sample history, refractory gap and peak count; tests the middle sample
// ----------------------------------------------------------------------------
module tpc_detect
   import tpc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          take,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          last_sample,
   output logic                          peak,
   output logic [COUNT_BITS-1:0]         count
);

   localparam int CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
   localparam logic [GAP_BITS-1:0] GAP_MAX = '1;

   logic signed [SAMPLE_BITS-1:0] older_ff,  older_in;
   logic signed [SAMPLE_BITS-1:0] middle_ff, middle_in;
   logic [SEEN_BITS-1:0]          seen_ff,   seen_in;
   logic [GAP_BITS-1:0]           gap_ff,    gap_in;
   logic                          peak_seen_ff, peak_seen_in;
   logic [COUNT_BITS-1:0]         total_ff,  total_in;

   logic signed [CMP_BITS-1:0] middle_ext;
   logic signed [CMP_BITS-1:0] thr_ext;
   logic                       gate_open;
   logic                       is_peak;

   assign middle_ext = CMP_BITS'(middle_ff);
   assign thr_ext    = CMP_BITS'(cfg.peak_threshold);

   // refractory gate passes before the first peak of a record, then once the gap exceeds refractory_samples
   assign gate_open = !peak_seen_ff ||
                      (gap_ff > {{(GAP_BITS-CFG_BITS){1'b0}}, cfg.refractory_samples});

   assign is_peak = (seen_ff == SEEN_FULL) && gate_open && (middle_ext > thr_ext) &&
                    (middle_ff >= sample) && (middle_ff > older_ff);

   always_comb begin
      older_in     = middle_ff;
      middle_in    = sample;
      seen_in      = (seen_ff == SEEN_FULL) ? seen_ff : seen_ff + 1'b1;
      gap_in       = gap_ff;
      peak_seen_in = peak_seen_ff | is_peak;
      total_in     = total_ff + COUNT_BITS'(is_peak);
      if (is_peak) begin
         gap_in = GAP_BITS'(1);
      end else if ((seen_ff == SEEN_FULL) && (gap_ff != GAP_MAX)) begin
         gap_in = gap_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_sample)) begin
         older_ff     <= '0;
         middle_ff    <= '0;
         seen_ff      <= '0;
         gap_ff       <= '0;
         peak_seen_ff <= 1'b0;
         total_ff     <= '0;
      end else if (take) begin
         older_ff     <= older_in;
         middle_ff    <= middle_in;
         seen_ff      <= seen_in;
         gap_ff       <= gap_in;
         peak_seen_ff <= peak_seen_in;
         total_ff     <= total_in;
      end
   end

   assign peak  = is_peak;
   assign count = total_in;

endmodule

@@ hdl/tpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_checker
// port level checks of the threshold peak counter, bound to the top level
// ----------------------------------------------------------------------------
module tpc_checker
   import tpc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_peak,
   input logic [COUNT_BITS-1:0] rsp_count,
   input logic                  rsp_done
);

   logic                  rsp_fire;
   logic [SEEN_BITS-1:0]  pos_ff;
   logic [COUNT_BITS-1:0] prev_count_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   // results delivered so far in the current record, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         prev_count_ff <= '0;
      end else if (rsp_fire) begin
         pos_ff        <= rsp_done ? '0 :
                          ((pos_ff == SEEN_FULL) ? pos_ff : pos_ff + 1'b1);
         prev_count_ff <= rsp_count;
      end
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted sample gave no result");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled result dropped");

   a_edge_no_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && (pos_ff != SEEN_FULL)) |-> (!rsp_peak && (rsp_count == '0)))
      else $error("peak reported before a center exists");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && (pos_ff == SEEN_FULL)) |->
         (rsp_count == prev_count_ff + COUNT_BITS'(rsp_peak)))
      else $error("peak count out of step with peak flags");

endmodule

bind threshold_peak_counter tpc_checker u_tpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_peak  (rsp_chan.peak_at_middle),
   .rsp_count (rsp_chan.peak_count),
   .rsp_done  (rsp_chan.record_done)
);
